// ===== src/rafb_pkg.sv =====
// Shared types, constants and header tables of the radio API frame builder.
package rafb_pkg;

    // Input command codes (carried on tuser)
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Frame kinds
    localparam logic KIND_AT = 1'b0;
    localparam logic KIND_TX = 1'b1;

    // Field widths
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PLEN_W  = 9;
    localparam int unsigned STEP_W  = 5;
    localparam int unsigned FLEN_W  = 10;
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 8;

    // Payload limit; longer requests are clamped
    localparam logic [PLEN_W-1:0] MAX_PAYLOAD = PLEN_W'(256);

    // Header sizes in bytes, delimiter and length included
    localparam logic [STEP_W-1:0] HDR_LEN_AT = STEP_W'(7);
    localparam logic [STEP_W-1:0] HDR_LEN_TX = STEP_W'(17);
    // Bytes before the frame type do not enter the checksum
    localparam logic [STEP_W-1:0] SUM_FIRST_STEP = STEP_W'(3);

    // Fixed header bytes
    localparam logic [BYTE_W-1:0] DELIM       = 8'h7E;
    localparam logic [BYTE_W-1:0] TYPE_AT     = 8'h08;
    localparam logic [BYTE_W-1:0] AT_FRAME_ID = 8'h17;
    localparam logic [BYTE_W-1:0] TYPE_TX     = 8'h10;
    localparam logic [BYTE_W-1:0] BCAST_HI    = 8'hFF;
    localparam logic [BYTE_W-1:0] BCAST_LO    = 8'hFE;

    // Queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One classified work item
    typedef struct packed {
        logic                is_start;
        logic                frame_kind;
        logic [CODE_W-1:0]   at_code;
        logic [BYTE_W-1:0]   frame_id;
        logic [PLEN_W-1:0]   plen;
        logic [BYTE_W-1:0]   data;
        logic                last;      // checksum follows this item
    } t_entry;

    // Queue status toward the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // AT command letter pair; unknown codes give zeros
    function automatic logic [BYTE_W-1:0] at_letter(input logic [CODE_W-1:0] code,
                                                    input logic second);
        logic [2*BYTE_W-1:0] pair;
        case (code)
            4'd0:    pair = 16'h5450; // TP
            4'd1:    pair = 16'h4454; // DT
            4'd2:    pair = 16'h4E50; // NP
            4'd3:    pair = 16'h4252; // BR
            4'd4:    pair = 16'h4D54; // MT
            4'd5:    pair = 16'h4E48; // NH
            4'd6:    pair = 16'h4E49; // NI
            4'd7:    pair = 16'h5454; // TT
            4'd8:    pair = 16'h544F; // TO
            default: pair = 16'h0000;
        endcase
        return second ? pair[BYTE_W-1:0] : pair[2*BYTE_W-1:BYTE_W];
    endfunction

    // Header byte at a given position of the frame
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic kind,
                                                   input logic [CODE_W-1:0] code,
                                                   input logic [BYTE_W-1:0] fid,
                                                   input logic [PLEN_W-1:0] plen,
                                                   input logic [STEP_W-1:0] step);
        logic [FLEN_W-1:0] flen;
        logic [BYTE_W-1:0] b;
        flen = {1'b0, plen} + (kind ? FLEN_W'(HDR_LEN_TX - SUM_FIRST_STEP)
                                    : FLEN_W'(HDR_LEN_AT - SUM_FIRST_STEP));
        case (step)
            5'd0: b = DELIM;
            5'd1: b = {6'b0, flen[FLEN_W-1:BYTE_W]};
            5'd2: b = flen[BYTE_W-1:0];
            5'd3: b = kind ? TYPE_TX : TYPE_AT;
            5'd4: b = kind ? fid : AT_FRAME_ID;
            5'd5: b = kind ? 8'h00 : at_letter(code, 1'b0);
            5'd6: b = kind ? 8'h00 : at_letter(code, 1'b1);
            5'd11, 5'd12, 5'd13: b = BCAST_HI;
            5'd14: b = BCAST_LO;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== src/radio_api_frame_builder.sv =====
// Top level of the radio API frame builder: front end, work queue, byte emitter.
//
//  channel  | dir | handshake                          | payload
//  ---------+-----+------------------------------------+-------------------------------------
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready  | tuser: cmd; tdata: kind, code, id,
//           |     |                                    |   length, data byte
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready  | tdata: out_byte; tlast: end_of_frame
//
// A payload byte passes the queue, then the output register. Bytes stream at one per cycle
// while the receiver is ready. A start transaction yields 7 (AT) or 17 (transmit request)
// header bytes, plus the checksum when the payload is empty; the 4-entry queue absorbs
// input meanwhile. Reset (i_rst_n low, synchronous) closes any frame and empties the queue.
// Output stalls back up the queue; input stalls only when the queue is full.
module radio_api_frame_builder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [0] frame_kind, [4:1] at_code, [12:5] frame_id, [21:13] payload_length,
    // [29:22] data_byte, [31:30] zero
    input  logic [rafb_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] cmd
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] out_byte
    output logic [rafb_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                             o_m_axis_tlast
);
    import rafb_pkg::*;

    t_entry     push_entry;
    t_entry     head;
    t_fifo_stat fifo_stat;
    logic       push;
    logic       pop;

    // Classification
    rafb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_cmd            (i_s_axis_tuser),
        .i_frame_kind     (i_s_axis_tdata[0]),
        .i_at_code        (i_s_axis_tdata[4:1]),
        .i_frame_id       (i_s_axis_tdata[12:5]),
        .i_payload_length (i_s_axis_tdata[21:13]),
        .i_data_byte      (i_s_axis_tdata[29:22]),
        .i_fifo_stat      (fifo_stat),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    // Work queue
    rafb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (fifo_stat)
    );

    // Byte emitter
    rafb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_fifo_stat (fifo_stat),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

endmodule

// ===== src/rafb_front.sv =====
// Front end: accepts input transactions, tracks the open frame and queues work.
module rafb_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_cmd,
    input  logic                             i_frame_kind,
    input  logic [rafb_pkg::CODE_W-1:0]      i_at_code,
    input  logic [rafb_pkg::BYTE_W-1:0]      i_frame_id,
    input  logic [rafb_pkg::PLEN_W-1:0]      i_payload_length,
    input  logic [rafb_pkg::BYTE_W-1:0]      i_data_byte,
    input  rafb_pkg::t_fifo_stat             i_fifo_stat,
    output logic                             o_push,
    output rafb_pkg::t_entry                 o_entry
);
    import rafb_pkg::*;

    logic              r_open;
    logic [PLEN_W-1:0] r_remaining;
    logic              n_open;
    logic [PLEN_W-1:0] n_remaining;
    logic              accept;
    logic [PLEN_W-1:0] plen_sat;

    assign o_ready  = !i_fifo_stat.full;
    assign accept   = i_valid && o_ready;
    assign plen_sat = (i_payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : i_payload_length;

    // Classify: starts always queue, payload bytes only inside an open frame
    always_comb begin
        n_open      = r_open;
        n_remaining = r_remaining;
        o_push      = 1'b0;
        o_entry.is_start   = (i_cmd == CMD_START);
        o_entry.frame_kind = i_frame_kind;
        o_entry.at_code    = i_at_code;
        o_entry.frame_id   = i_frame_id;
        o_entry.plen       = plen_sat;
        o_entry.data       = i_data_byte;
        o_entry.last       = 1'b0;
        if (accept) begin
            if (i_cmd == CMD_START) begin
                o_push       = 1'b1;
                o_entry.last = (plen_sat == '0);
                n_open       = (plen_sat != '0);
                n_remaining  = plen_sat;
            end else if (r_open) begin
                o_push       = 1'b1;
                o_entry.last = (r_remaining == PLEN_W'(1));
                n_remaining  = r_remaining - PLEN_W'(1);
                n_open       = (r_remaining != PLEN_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= '0;
        end else begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

    // A closed frame expects no bytes
    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> r_remaining == '0)
        else $error("front: closed frame with bytes pending");

    // Queuing a closing item leaves no frame open
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_entry.last |=> !r_open)
        else $error("front: frame still open after its last item");

endmodule

// ===== src/rafb_fifo.sv =====
// Short first-word-fall-through queue of work items between front and back.
module rafb_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rafb_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output rafb_pkg::t_entry     o_head,
    output rafb_pkg::t_fifo_stat o_stat
);
    import rafb_pkg::*;

    t_entry                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_stat.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
        end
    end

endmodule

// ===== src/rafb_back.sv =====
// Back end: walks header, payload and checksum bytes into the output register.
module rafb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rafb_pkg::t_entry            i_head,
    input  rafb_pkg::t_fifo_stat        i_fifo_stat,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rafb_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_last
);
    import rafb_pkg::*;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic [STEP_W-1:0] r_step;
    logic [BYTE_W-1:0] r_sum;

    logic              n_out_valid;
    logic [BYTE_W-1:0] n_out_byte;
    logic              n_out_last;
    logic [STEP_W-1:0] n_step;
    logic [BYTE_W-1:0] n_sum;

    logic              advance;
    logic              fire;
    logic [STEP_W-1:0] hdr_len;
    logic [STEP_W-1:0] body_len;
    logic [STEP_W-1:0] last_idx;
    logic              is_ck;
    logic              summed;
    logic [BYTE_W-1:0] cur_byte;

    assign advance  = !r_out_valid || i_ready;
    assign fire     = advance && !i_fifo_stat.empty;
    assign hdr_len  = i_head.frame_kind ? HDR_LEN_TX : HDR_LEN_AT;
    assign body_len = i_head.is_start ? hdr_len : STEP_W'(1);
    assign last_idx = body_len - STEP_W'(!i_head.last);
    assign is_ck    = i_head.last && (r_step == body_len);
    assign summed   = !is_ck && (!i_head.is_start || r_step >= SUM_FIRST_STEP);

    // Byte selection for the current step
    always_comb begin
        if (is_ck) begin
            cur_byte = ~r_sum;
        end else if (i_head.is_start) begin
            cur_byte = hdr_byte(i_head.frame_kind, i_head.at_code, i_head.frame_id,
                                i_head.plen, r_step);
        end else begin
            cur_byte = i_head.data;
        end
    end

    assign o_pop = fire && (r_step == last_idx);

    // Next state: one byte per advance, checksum accumulates summed bytes
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_step      = r_step;
        n_sum       = r_sum;
        if (fire) begin
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_out_last  = is_ck;
            n_step      = o_pop ? '0 : r_step + STEP_W'(1);
            if (i_head.is_start && r_step == '0) begin
                n_sum = '0;
            end else if (summed) begin
                n_sum = r_sum + cur_byte;
            end
        end else if (advance) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_sum       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_sum       <= n_sum;
        end
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    // Step counter stays inside the longest frame
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= HDR_LEN_TX)
        else $error("back: step counter out of range");

    // Checksum byte always retires its item and rewinds the step counter
    a_ck_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && is_ck |-> o_pop ##1 r_step == '0)
        else $error("back: checksum did not close the item");

endmodule

// ===== dv/tb_radio_api_frame_builder.sv =====
// Self-checking testbench of the radio API frame builder: directed table, then random frames.
`timescale 1ns / 1ps

module tb_radio_api_frame_builder;
    import rafb_pkg::*;

    // Run shape
    localparam int     DIR_ROWS     = 23;
    localparam int     RANDOM_ITEMS = 350;
    localparam int     HOLD_AFTER   = DIR_ROWS + 20;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     TAIL_CYCLES  = 40;
    localparam longint LIMIT_NS     = 40_000_000;
    localparam int     MAX_REPORTS  = 10;

    // Frame length field is payload plus the bytes from the frame type up to the payload
    localparam logic [FLEN_W-1:0] AT_LEN_BASE = FLEN_W'(4);
    localparam logic [FLEN_W-1:0] TX_LEN_BASE = FLEN_W'(14);
    localparam int                TX_ZERO_RUN = 6;

    // AT letter pair indexes
    localparam logic [CODE_W-1:0] AT_TP          = 4'd0;
    localparam logic [CODE_W-1:0] AT_DT          = 4'd1;
    localparam logic [CODE_W-1:0] AT_NP          = 4'd2;
    localparam logic [CODE_W-1:0] AT_BR          = 4'd3;
    localparam logic [CODE_W-1:0] AT_MT          = 4'd4;
    localparam logic [CODE_W-1:0] AT_NH          = 4'd5;
    localparam logic [CODE_W-1:0] AT_NI          = 4'd6;
    localparam logic [CODE_W-1:0] AT_TT          = 4'd7;
    localparam logic [CODE_W-1:0] AT_TO          = 4'd8;
    localparam logic [CODE_W-1:0] AT_FIRST_UNDEF = 4'd9;
    localparam logic [CODE_W-1:0] AT_UNDEF       = 4'd15;

    // Letter pairs, first letter in the upper byte; undefined codes give zeros
    localparam logic [15:0] AT_PAIRS [16] = '{
        16'h5450, 16'h4454, 16'h4E50, 16'h4252, 16'h4D54, 16'h4E48, 16'h4E49, 16'h5454,
        16'h544F, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    // Typed expectation: up to 18 bytes, first byte in the top bits
    localparam int TYPED_W = 18 * BYTE_W;

    typedef struct packed {
        logic              cmd;
        logic              kind;
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] fid;
        logic [PLEN_W-1:0] plen;
        logic [BYTE_W-1:0] data;
    } t_req;

    typedef struct packed {
        t_req               req;
        logic               typed_on;
        logic [4:0]         typed_n;
        logic [TYPED_W-1:0] typed;
    } t_row;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              eof;
    } t_wire_byte;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // [0] kind, [4:1] code, [12:5] id, [21:13] len, [29:22] data
    logic                   i_s_axis_tuser;   // [0] cmd
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // [7:0] out_byte
    logic                   o_m_axis_tlast;

    radio_api_frame_builder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Predictor state
    logic              frame_live;
    logic [PLEN_W-1:0] left_cnt;
    logic [BYTE_W-1:0] chk_acc;

    t_wire_byte step_bytes [$];     // bytes caused by the transaction just taken
    t_wire_byte wire_bytes_q [$];   // bytes still owed on the output
    int         reqs_taken    = 0;
    int         mismatch_cnt  = 0;
    bit         hold_done     = 1'b0;

    // Directed table
    t_row dir_tab [DIR_ROWS] = '{
        // AT frame, empty payload: header then checksum at once
        '{'{CMD_START, KIND_AT, AT_TP, 8'h00, 9'd0, 8'h00}, 1'b1, 5'd8,
          {8'h7E, 8'h00, 8'h04, 8'h08, 8'h17, 8'h54, 8'h50, 8'h3C, 80'h0}},
        // byte with no open frame is dropped, unused fields at max
        '{'{CMD_DATA, KIND_TX, AT_UNDEF, 8'hFF, 9'h1FF, 8'hFF}, 1'b1, 5'd0, '0},
        // transmit request, empty payload, id all ones
        '{'{CMD_START, KIND_TX, AT_TP, 8'hFF, 9'd0, 8'h00}, 1'b1, 5'd18,
          {8'h7E, 8'h00, 8'h0E, 8'h10, 8'hFF, 48'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
           16'h0, 8'hF5}},
        // undefined letter pair gives zeros
        '{'{CMD_START, KIND_AT, AT_UNDEF, 8'h00, 9'd0, 8'h00}, 1'b1, 5'd8,
          {8'h7E, 8'h00, 8'h04, 8'h08, 8'h17, 8'h00, 8'h00, 8'hE0, 80'h0}},
        '{'{CMD_START, KIND_AT, AT_DT, 8'h5A, 9'd2, 8'hA5}, 1'b0, 5'd0, '0},
        '{'{CMD_DATA, KIND_AT, AT_TP, 8'h00, 9'd0, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_DATA, KIND_TX, AT_UNDEF, 8'hFF, 9'h1FF, 8'hFF}, 1'b0, 5'd0, '0},
        '{'{CMD_START, KIND_AT, AT_NP, 8'h00, 9'd1, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_DATA, KIND_AT, AT_TP, 8'h00, 9'd0, 8'h80}, 1'b0, 5'd0, '0},
        '{'{CMD_START, KIND_AT, AT_BR, 8'h00, 9'd0, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_START, KIND_AT, AT_MT, 8'h00, 9'd0, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_START, KIND_AT, AT_NH, 8'h00, 9'd0, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_START, KIND_AT, AT_NI, 8'h00, 9'd0, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_START, KIND_TX, AT_TP, 8'h00, 9'd3, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_DATA, KIND_AT, AT_TP, 8'h00, 9'd0, 8'h55}, 1'b0, 5'd0, '0},
        '{'{CMD_DATA, KIND_AT, AT_TP, 8'h00, 9'd0, 8'hAA}, 1'b0, 5'd0, '0},
        // start while open: the transmit request above is cut short, with no checksum
        '{'{CMD_START, KIND_AT, AT_FIRST_UNDEF, 8'h00, 9'h0FF, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_DATA, KIND_AT, AT_TP, 8'h00, 9'd0, 8'h01}, 1'b0, 5'd0, '0},
        // oversized length is clamped in the length field
        '{'{CMD_START, KIND_TX, AT_TP, 8'h5A, 9'h1FF, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_START, KIND_AT, AT_TO, 8'h00, 9'h100, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_START, KIND_AT, AT_TT, 8'h00, 9'd1, 8'h00}, 1'b0, 5'd0, '0},
        '{'{CMD_DATA, KIND_AT, AT_TP, 8'h00, 9'd0, 8'h7F}, 1'b0, 5'd0, '0},
        '{'{CMD_DATA, KIND_AT, AT_TP, 8'h00, 9'd0, 8'h00}, 1'b0, 5'd0, '0}
    };

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predictor helpers
    function automatic void emit_byte(input logic [BYTE_W-1:0] b, input logic eof);
        t_wire_byte w;
        w.b   = b;
        w.eof = eof;
        step_bytes.push_back(w);
    endfunction

    function automatic void emit_summed(input logic [BYTE_W-1:0] b);
        chk_acc = chk_acc + b;
        emit_byte(b, 1'b0);
    endfunction

    function automatic void close_frame();
        emit_byte(8'hFF - chk_acc, 1'b1);
        frame_live = 1'b0;
        left_cnt   = '0;
    endfunction

    // Bytes on the wire caused by one transaction
    function automatic void build_frame_bytes(input t_req r);
        logic [PLEN_W-1:0] n;
        logic [FLEN_W-1:0] flen;
        logic [15:0]       pair;
        if (r.cmd == CMD_START) begin
            n    = (r.plen > MAX_PAYLOAD) ? MAX_PAYLOAD : r.plen;
            flen = {1'b0, n} + ((r.kind == KIND_TX) ? TX_LEN_BASE : AT_LEN_BASE);
            chk_acc = '0;
            emit_byte(DELIM, 1'b0);
            emit_byte(BYTE_W'(flen >> BYTE_W), 1'b0);
            emit_byte(flen[BYTE_W-1:0], 1'b0);
            if (r.kind == KIND_AT) begin
                pair = AT_PAIRS[r.code];
                emit_summed(TYPE_AT);
                emit_summed(AT_FRAME_ID);
                emit_summed(pair[15:8]);
                emit_summed(pair[7:0]);
            end else begin
                emit_summed(TYPE_TX);
                emit_summed(r.fid);
                for (int i = 0; i < TX_ZERO_RUN; i++) emit_summed(8'h00);
                emit_summed(BCAST_HI);
                emit_summed(BCAST_HI);
                emit_summed(BCAST_HI);
                emit_summed(BCAST_LO);
                emit_summed(8'h00);
                emit_summed(8'h00);
            end
            frame_live = 1'b1;
            left_cnt   = n;
            if (n == 0) close_frame();
        end else if (frame_live) begin
            emit_summed(r.data);
            if (left_cnt != 0) left_cnt--;
            if (left_cnt == 0) close_frame();
        end
    endfunction

    // Mostly no gap, some short ones, a few long
    function automatic int pick_gap(input bit burst);
        int p;
        p = $urandom_range(0, 99);
        if (burst || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_req rand_req(input logic cmd);
        t_req r;
        r.cmd  = cmd;
        r.kind = 1'($urandom);
        r.code = CODE_W'($urandom);
        r.fid  = BYTE_W'($urandom);
        r.plen = PLEN_W'($urandom);
        r.data = BYTE_W'($urandom);
        return r;
    endfunction

    function automatic void log_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) $display("mismatch %0d: %s", mismatch_cnt, what);
    endfunction

    // Offer one transaction, predict on acceptance, then idle for a random gap, possibly none
    task automatic send_req(input t_req r, input bit typed_on, input int typed_n,
                            input logic [TYPED_W-1:0] typed, input bit burst);
        int         gap;
        t_wire_byte w;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= r.cmd;
        i_s_axis_tdata  <= {2'b00, r.data, r.plen, r.fid, r.code, r.kind};
        do @(posedge i_clk); while (!o_s_axis_tready);
        reqs_taken++;
        step_bytes.delete();
        build_frame_bytes(r);
        if (typed_on) begin
            for (int k = 0; k < typed_n; k++) begin
                w.b   = typed[TYPED_W-1-BYTE_W*k -: BYTE_W];
                w.eof = (k == typed_n - 1);
                wire_bytes_q.push_back(w);
            end
        end else begin
            foreach (step_bytes[k]) wire_bytes_q.push_back(step_bytes[k]);
        end
        gap = pick_gap(burst);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Output check against the oldest owed byte
    always @(posedge i_clk) begin : wire_check
        t_wire_byte want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (wire_bytes_q.size() == 0) begin
                log_mismatch($sformatf("unexpected byte %02h last %0b",
                                       o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = wire_bytes_q.pop_front();
                if (o_m_axis_tdata !== want.b || o_m_axis_tlast !== want.eof)
                    log_mismatch($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                           want.b, want.eof, o_m_axis_tdata, o_m_axis_tlast));
            end
        end
    end

    // Receiver: random ready runs, plus one long hold-off while input keeps coming
    initial begin : sink_ready
        int run;
        i_m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!hold_done && reqs_taken >= HOLD_AFTER) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
                i_m_axis_tready <= 1'b1;
                repeat (run) @(posedge i_clk);
                run = pick_gap(1'b0);
                if (run > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (run) @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus
    initial begin : stim
        t_req r;
        int   n;
        int   sel;
        bit   burst;
        frame_live = 1'b0;
        left_cnt   = '0;
        chk_acc    = '0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= CMD_START;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows
        for (int i = 0; i < DIR_ROWS; i++)
            send_req(dir_tab[i].req, dir_tab[i].typed_on, dir_tab[i].typed_n,
                     dir_tab[i].typed, 1'b0);

        // One full-size frame with a request at or above the limit, carries the long hold-off
        r      = rand_req(CMD_START);
        r.plen = PLEN_W'($urandom_range(MAX_PAYLOAD, 511));
        send_req(r, 1'b0, 0, '0, 1'b0);
        for (int k = 0; k < MAX_PAYLOAD; k++)
            send_req(rand_req(CMD_DATA), 1'b0, 0, '0, k < 128);

        // Random frames, some cut short, plus stray bytes and stray starts
        while (reqs_taken < DIR_ROWS + RANDOM_ITEMS) begin
            sel   = $urandom_range(0, 99);
            burst = ($urandom_range(0, 3) == 0);
            if (sel < 80) begin
                r      = rand_req(CMD_START);
                r.plen = ($urandom_range(0, 99) < 80) ? PLEN_W'($urandom_range(0, 6))
                                                      : PLEN_W'($urandom_range(7, 24));
                send_req(r, 1'b0, 0, '0, burst);
                n = r.plen;
                if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
                for (int k = 0; k < n; k++)
                    send_req(rand_req(CMD_DATA), 1'b0, 0, '0, burst);
            end else if (sel < 90) begin
                send_req(rand_req(CMD_DATA), 1'b0, 0, '0, burst);
            end else begin
                send_req(rand_req(CMD_START), 1'b0, 0, '0, burst);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain, then let a header burst from any late start come out
        while (wire_bytes_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/rafb_pkg.sv
src/rafb_front.sv
src/rafb_fifo.sv
src/rafb_back.sv
src/radio_api_frame_builder.sv
dv/tb_radio_api_frame_builder.sv
